FILE: sv/dlm_pkg.sv
// ----------------------------------------------------------------------------
// dlm_pkg
// shared constants, types and decimal helpers of the decimal long multiplier
// ----------------------------------------------------------------------------
package dlm_pkg;

   // operand length limit, default for the top-level parameter
   localparam int NUM_DIGITS_DEF = 64;

   // packed bcd digits per result word
   localparam int DIGITS_PER_GROUP = 4;
   localparam int GROUP_W = 4 * DIGITS_PER_GROUP;

   localparam int DIGIT_W = 4;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // decimal split of a small sum: q = (v * 205) >> 11 is exact for v below 1029
   localparam int DEC_BASE = 10;
   localparam int DEC_RECIP = 205;
   localparam int DEC_SHIFT = 11;

   // skid queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      digit_type digit_a;
      digit_type digit_b;
      logic      last_pair;
      logic      bad;
   } item_type;

   typedef struct packed {
      logic [QUEUE_LEVEL_W-1:0] level;
   } fe_status_type;

   typedef struct packed {
      logic loading;
      logic emitting;
   } be_status_type;

   function automatic digit_type dec_quot(input logic [6:0] v);
      logic [14:0] m;
      m = 15'(v) * 15'(DEC_RECIP);
      return DIGIT_W'(m >> DEC_SHIFT);
   endfunction

   function automatic digit_type dec_rem(input logic [6:0] v);
      logic [6:0] r;
      r = v - 7'(dec_quot(v)) * 7'(DEC_BASE);
      return r[DIGIT_W-1:0];
   endfunction

endpackage

FILE: sv/decimal_long_multiplier.sv
// multiply: for k stored pairs the back runs k rows, each of k multiply steps, a tail step
//    and a row step, starting the cycle after the back pops the last pair; then the output stage packs the first group
// throughput: pairs enter one a cycle while loading; each group takes four product memory
//    reads, a load and the handshake; one product at a time
// reset: synchronous, clears control only; operand and product memories are not cleared
// ----------------------------------------------------------------------------
// decimal_long_multiplier
// bcd schoolbook multiplier of two equal-length operands, packed bcd result words
// ----------------------------------------------------------------------------
module decimal_long_multiplier #(
   parameter int NUM_DIGITS = dlm_pkg::NUM_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // digit pair words, most significant pair first
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_digit_a,
   input  logic [3:0]  req_digit_b,
   input  logic        req_last_pair,
   // product words, most significant group first
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_product_group,
   output logic        rsp_last_group,
   output logic        rsp_input_error
);

   localparam int LW = dlm_pkg::QUEUE_LEVEL_W;

   // queue handoff between front and back
   dlm_pkg::item_type      q_item;
   logic                   q_valid;
   logic                   q_take;
   dlm_pkg::fe_status_type fe_stat;
   dlm_pkg::be_status_type be_stat;

   // front: takes words, marks digits above nine, buffers in a two-entry queue
   dlm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_digit_a   (req_digit_a),
      .req_digit_b   (req_digit_b),
      .req_last_pair (req_last_pair),
      .q_item        (q_item),
      .q_valid       (q_valid),
      .q_take        (q_take),
      .stat          (fe_stat)
   );

   // back: stores operands, runs the schoolbook rows, packs and sends groups
   dlm_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_item            (q_item),
      .q_valid           (q_valid),
      .q_take            (q_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_product_group (rsp_product_group),
      .rsp_last_group    (rsp_last_group),
      .rsp_input_error   (rsp_input_error),
      .stat              (be_stat)
   );

   // a result word only comes out while the back is emitting a product
   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> be_stat.emitting)
      else $error("result word outside the emit phase");

   // after the last group is taken the back goes back to loading operands
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_group) |=> be_stat.loading)
      else $error("back not loading after final group");

   // a word taken with no pop grows the queue by one
   a_queue_grow: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !(q_valid && q_take)) |=>
         (fe_stat.level == $past(fe_stat.level) + LW'(1)))
      else $error("queue level did not follow a push");

   // an empty queue never shows a word to the back
   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      (fe_stat.level == '0) |-> !q_valid)
      else $error("queue shows a word while empty");

endmodule

FILE: sv/dlm_front.sv
// ----------------------------------------------------------------------------
// dlm_front
// takes digit pairs, flags non-decimal digits, holds them in a short queue
// ----------------------------------------------------------------------------
module dlm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [3:0]            req_digit_a,
   input  logic [3:0]            req_digit_b,
   input  logic                  req_last_pair,
   output dlm_pkg::item_type     q_item,
   output logic                  q_valid,
   input  logic                  q_take,
   output dlm_pkg::fe_status_type stat
);

   localparam int PW = dlm_pkg::QUEUE_PTR_W;
   localparam int LW = dlm_pkg::QUEUE_LEVEL_W;

   dlm_pkg::item_type fifo_ff [dlm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;

   dlm_pkg::item_type new_item;
   logic push;
   logic pop;

   // classify the incoming word
   always_comb begin
      new_item.digit_a   = req_digit_a;
      new_item.digit_b   = req_digit_b;
      new_item.last_pair = req_last_pair;
      new_item.bad       = (req_digit_a > dlm_pkg::DIGIT_MAX) ||
                           (req_digit_b > dlm_pkg::DIGIT_MAX);
   end

   assign req_stall = (level_ff == LW'(dlm_pkg::QUEUE_DEPTH));
   assign q_valid   = (level_ff != '0);
   assign q_item    = fifo_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_valid && q_take;
   assign stat.level = level_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      level_in  = level_ff + LW'(push) - LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: sv/dlm_back.sv
// ----------------------------------------------------------------------------
// dlm_back
// operand store, shared digit multiply-accumulate unit and group packer
// ----------------------------------------------------------------------------
module dlm_back #(
   parameter int NUM_DIGITS = dlm_pkg::NUM_DIGITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dlm_pkg::item_type      q_item,
   input  logic                   q_valid,
   output logic                   q_take,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_product_group,
   output logic                   rsp_last_group,
   output logic                   rsp_input_error,
   output dlm_pkg::be_status_type stat
);

   localparam int CW = $clog2(NUM_DIGITS + 1);
   localparam int AW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int PDEPTH = 2 * NUM_DIGITS;
   localparam int PW = $clog2(PDEPTH);
   localparam int GW = $clog2((NUM_DIGITS + 1) / 2 + 1);
   localparam int DW = dlm_pkg::DIGIT_W;
   localparam int GRW = dlm_pkg::GROUP_W;
   localparam int DCW = $clog2(dlm_pkg::DIGITS_PER_GROUP);

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_TAIL = 3'd2;
   localparam logic [2:0] S_ROW  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;
   localparam logic [2:0] S_HOLD = 3'd5;

   localparam logic [2:0] PAD_EMPTY = 3'd4;
   localparam logic [2:0] PAD_ODD   = 3'd2;

   // memories
   logic [DW-1:0] a_mem [NUM_DIGITS];
   logic [DW-1:0] b_mem [NUM_DIGITS];
   logic [DW-1:0] p_mem [PDEPTH];
   logic [DW-1:0] a_rd_ff, b_rd_ff, p_rd_ff;

   // control
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          error_ff, error_in;
   logic [AW-1:0] km1_ff, km1_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;

   // multiply pipeline stage
   logic          m_vld_ff, m_vld_in;
   logic [PW-1:0] m_pos_ff, m_pos_in;
   logic          m_frow_ff, m_frow_in;
   logic          m_fcol_ff, m_fcol_in;
   logic [DW-1:0] carry_ff, carry_in;

   // output stage
   logic [2:0]     pad_ff, pad_in;
   logic [PW-1:0]  oaddr_ff, oaddr_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [GW-1:0]  grp_ff, grp_in;
   logic           o_vld_ff, o_vld_in;
   logic           o_zero_ff, o_zero_in;
   logic           o_end_ff, o_end_in;
   logic [GRW-5:0] acc_ff, acc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [GRW-1:0] rsp_group_ff, rsp_group_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_err_ff, rsp_err_in;

   // combinational helpers
   logic          pop;
   logic          store_ok;
   logic [CW-1:0] count_next;
   logic [CW-1:0] k_sel;
   logic [CW:0]   k_plus1;
   logic [2:0]    pad_calc;
   logic [GW-1:0] grp_calc;
   logic [PW-1:0] mul_pos;
   logic [PW-1:0] p_raddr;
   logic          p_we;
   logic [PW-1:0] p_waddr;
   logic [DW-1:0] p_wdata;
   logic [7:0]    mac_prod;
   logic [6:0]    mac_sum;
   logic [DW-1:0] mac_digit;
   logic [DW-1:0] mac_carry;
   logic [DW-1:0] out_digit;
   logic          taken;

   assign q_take        = (state_ff == S_LOAD);
   assign pop           = q_valid && q_take;
   assign store_ok      = !q_item.bad && (count_ff < CW'(NUM_DIGITS));
   assign count_next    = count_ff + CW'(store_ok);
   assign k_sel         = (state_ff == S_LOAD) ? count_next : count_ff;
   assign k_plus1       = {1'b0, k_sel} + (CW+1)'(1);
   assign mul_pos       = PW'(i_ff) + PW'(j_ff) + PW'(1);
   assign taken         = rsp_valid_ff && !rsp_stall;

   // zero padding on top and group count for k digit pairs
   always_comb begin
      if (k_sel == '0) begin
         pad_calc = PAD_EMPTY;
         grp_calc = GW'(1);
      end else begin
         pad_calc = k_sel[0] ? PAD_ODD : 3'd0;
         grp_calc = GW'(k_plus1 >> 1);
      end
   end

   // digit multiply-accumulate with decimal carry
   always_comb begin
      mac_prod  = a_rd_ff * b_rd_ff;
      mac_sum   = {3'b0, (m_frow_ff ? '0 : p_rd_ff)} + mac_prod[6:0] +
                  {3'b0, (m_fcol_ff ? '0 : carry_ff)};
      mac_digit = dlm_pkg::dec_rem(mac_sum);
      mac_carry = dlm_pkg::dec_quot(mac_sum);
   end

   assign out_digit = o_zero_ff ? '0 : p_rd_ff;

   // product memory ports
   assign p_raddr = (state_ff == S_OUT) ? oaddr_ff : mul_pos;
   assign p_we    = m_vld_ff || (state_ff == S_ROW);
   assign p_waddr = m_vld_ff ? m_pos_ff : PW'(i_ff);
   assign p_wdata = m_vld_ff ? mac_digit : carry_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      km1_in       = km1_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      m_vld_in     = 1'b0;
      m_pos_in     = mul_pos;
      m_frow_in    = (i_ff == km1_ff);
      m_fcol_in    = (j_ff == km1_ff);
      carry_in     = m_vld_ff ? mac_carry : carry_ff;
      pad_in       = pad_ff;
      oaddr_in     = oaddr_ff;
      dcnt_in      = dcnt_ff;
      grp_in       = grp_ff;
      o_vld_in     = 1'b0;
      o_zero_in    = (pad_ff != '0);
      o_end_in     = (dcnt_ff == DCW'(dlm_pkg::DIGITS_PER_GROUP - 1));
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !taken;
      rsp_group_in = rsp_group_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      // pack digits into a group, hand the group over on its last digit
      if (o_vld_ff) begin
         acc_in = {acc_ff[GRW-9:0], out_digit};
         if (o_end_ff) begin
            rsp_valid_in = 1'b1;
            rsp_group_in = {acc_ff, out_digit};
            rsp_last_in  = (grp_ff == GW'(1));
            rsp_err_in   = error_ff;
         end
      end

      case (state_ff)
         S_LOAD: begin
            if (pop) begin
               count_in = count_next;
               if (!store_ok) begin
                  error_in = 1'b1;
               end
               if (q_item.last_pair) begin
                  km1_in = AW'(count_next - CW'(1));
                  i_in   = AW'(count_next - CW'(1));
                  j_in   = AW'(count_next - CW'(1));
                  if (count_next == '0) begin
                     pad_in   = pad_calc;
                     grp_in   = grp_calc;
                     oaddr_in = '0;
                     dcnt_in  = '0;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_MUL;
                  end
               end
            end
         end
         S_MUL: begin
            m_vld_in = 1'b1;
            if (j_ff == '0) begin
               state_in = S_TAIL;
            end else begin
               j_in = j_ff - AW'(1);
            end
         end
         S_TAIL: begin
            state_in = S_ROW;
         end
         S_ROW: begin
            // leading digit of the row takes the final carry
            if (i_ff == '0) begin
               pad_in   = pad_calc;
               grp_in   = grp_calc;
               oaddr_in = '0;
               dcnt_in  = '0;
               state_in = S_OUT;
            end else begin
               i_in     = i_ff - AW'(1);
               j_in     = km1_ff;
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            o_vld_in = 1'b1;
            dcnt_in  = dcnt_ff + DCW'(1);
            if (pad_ff != '0) begin
               pad_in = pad_ff - 3'd1;
            end else begin
               oaddr_in = oaddr_ff + PW'(1);
            end
            if (dcnt_ff == DCW'(dlm_pkg::DIGITS_PER_GROUP - 1)) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (taken) begin
               if (grp_ff == GW'(1)) begin
                  count_in = '0;
                  error_in = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  grp_in   = grp_ff - GW'(1);
                  state_in = S_OUT;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         error_ff     <= 1'b0;
         m_vld_ff     <= 1'b0;
         o_vld_ff     <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         m_vld_ff     <= m_vld_in;
         o_vld_ff     <= o_vld_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      km1_ff       <= km1_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      m_pos_ff     <= m_pos_in;
      m_frow_ff    <= m_frow_in;
      m_fcol_ff    <= m_fcol_in;
      carry_ff     <= carry_in;
      pad_ff       <= pad_in;
      oaddr_ff     <= oaddr_in;
      grp_ff       <= grp_in;
      o_zero_ff    <= o_zero_in;
      o_end_ff     <= o_end_in;
      acc_ff       <= acc_in;
      rsp_group_ff <= rsp_group_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // operand and product memories, registered reads
   always_ff @(posedge clock) begin
      if (pop && store_ok) begin
         a_mem[count_ff[AW-1:0]] <= q_item.digit_a;
         b_mem[count_ff[AW-1:0]] <= q_item.digit_b;
      end
      if (p_we) begin
         p_mem[p_waddr] <= p_wdata;
      end
      a_rd_ff <= a_mem[i_ff];
      b_rd_ff <= b_mem[j_ff];
      p_rd_ff <= p_mem[p_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_group = rsp_group_ff;
   assign rsp_last_group    = rsp_last_ff;
   assign rsp_input_error   = rsp_err_ff;
   assign stat.loading      = (state_ff == S_LOAD);
   assign stat.emitting     = (state_ff == S_OUT) || (state_ff == S_HOLD);

endmodule
